/* hw/rtl/tsd_pkg.sv */
package tsd_pkg;

    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = QPTR_W + 1;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_CMAP  = 3'd1;
    localparam logic [2:0] ERR_TYPE  = 3'd2;
    localparam logic [2:0] ERR_DEPTH = 3'd3;
    localparam logic [2:0] ERR_DESC  = 3'd4;

    localparam logic [7:0] TYPE_PLAIN  = 8'd2;
    localparam logic [7:0] TYPE_RLE    = 8'd10;
    localparam logic [7:0] DEPTH_24    = 8'd24;
    localparam logic [7:0] DEPTH_32    = 8'd32;
    localparam logic [7:0] RUN_FLAG    = 8'h80;
    localparam logic [7:0] RUN_LEN     = 8'h7F;
    localparam logic [7:0] DESC_TOP    = 8'h20;
    localparam logic [7:0] DESC_RIGHT  = 8'h10;
    localparam logic [7:0] DESC_ALPHA  = 8'h0F;
    localparam logic [3:0] ALPHA_8     = 4'd8;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  count;
        logic [15:0] col;
        logic [15:0] row;
        logic [2:0]  err;
        logic        last;
        logic        flip_rows;
        logic        flip_cols;
    } t_cmd;

endpackage

/* hw/rtl/tga_stream_decoder_core.sv */
// Truecolor image file decoder fed one byte per transaction.
// The slave channel carries one file byte in s_tdata; s_tuser high marks the
// first byte of a new file and abandons any file in progress.
// The master channel carries one result per transaction: m_tuser gives the
// kind (pixel or run, header accepted, error), m_tlast marks the result that
// completes the image, and m_tdata holds the components, count, position and
// error code.
// A result passes through the queue and then the result register before it is
// valid on m_tvalid.
// Bytes are taken at one per cycle while the queue is not full. Between the
// parser and the result stage sits a four-entry queue; the result stage holds
// back the next result while a run or pixel that crosses a row boundary has its
// column folded back into range by one subtraction per cycle, so narrow images
// with long runs can fill the queue and hold s_tready low for a while.
// When the receiver stalls, the result register holds its transaction, the
// queue fills and s_tready drops once it is full.
// Synchronous reset clears the queue and the result valid flag and returns the
// parser to waiting for a first byte; bytes before it are ignored.
module tga_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // red, green, blue, alpha, count, col, row, error_code
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);

    logic          push, full, q_valid, pop;
    tsd_pkg::t_cmd push_cmd, q_cmd, res;

    tsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .i_byte  (s_tdata),
        .i_start (s_tuser),
        .i_full  (full),
        .o_ready (s_tready),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    tsd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .o_pop   (pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_res   (res)
    );

    assign m_tdata = {5'd0, res.err, res.row, res.col, res.count,
                      res.alpha, res.blue, res.green, res.red};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

/* hw/rtl/tsd_front.sv */
module tsd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_start,
    input  logic          i_full,
    output logic          o_ready,
    output logic          o_push,
    output tsd_pkg::t_cmd o_cmd
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_PACKET = 3'd3;
    localparam logic [2:0] PH_PIXEL  = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic [4:0]  r_hidx, n_hidx;
    logic [7:0]  r_skip, n_skip;
    logic        r_run_mode, n_run_mode;
    logic [15:0] r_w, n_w;
    logic [15:0] r_h, n_h;
    logic        r_pb4, n_pb4;
    logic        r_flip_r, n_flip_r;
    logic        r_flip_c, n_flip_c;
    logic        r_is_run, n_is_run;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic [1:0]  r_bidx, n_bidx;
    logic [23:0] r_asm, n_asm;
    logic [31:0] r_area, n_area;
    logic [31:0] r_left, n_left;

    logic        accept;
    logic [2:0]  eff_phase;
    logic [4:0]  eff_hidx;
    logic        pix_done;
    logic [7:0]  cnt;
    logic        img_done;
    logic        empty;
    logic [2:0]  data_ph;

    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    assign eff_phase = i_start ? PH_HEADER : r_phase;
    assign eff_hidx  = i_start ? 5'd0 : r_hidx;
    assign data_ph   = r_run_mode ? PH_PACKET : PH_PIXEL;
    assign pix_done  = (r_bidx == 2'd3) || (r_bidx == 2'd2 && !r_pb4);
    assign empty     = (r_w == 16'd0) || (r_h == 16'd0);

    always_comb begin
        if (r_run_mode && r_is_run) begin
            cnt = (r_left < {24'd0, r_pkt_left}) ? r_left[7:0] : r_pkt_left;
        end else begin
            cnt = 8'd1;
        end
        img_done = ({24'd0, cnt} >= r_left);
    end

    always_comb begin
        n_phase    = r_phase;
        n_hidx     = r_hidx;
        n_skip     = r_skip;
        n_run_mode = r_run_mode;
        n_w        = r_w;
        n_h        = r_h;
        n_pb4      = r_pb4;
        n_flip_r   = r_flip_r;
        n_flip_c   = r_flip_c;
        n_is_run   = r_is_run;
        n_pkt_left = r_pkt_left;
        n_bidx     = r_bidx;
        n_asm      = r_asm;
        n_area     = r_area;
        n_left     = r_left;
        o_push     = 1'b0;
        o_cmd      = '0;
        if (accept) begin
            n_phase = eff_phase;
            unique case (eff_phase)
                PH_HEADER: begin
                    n_hidx = (eff_hidx < 5'd31) ? eff_hidx + 5'd1 : eff_hidx;
                    case (eff_hidx)
                        5'd0: n_skip = i_byte;
                        5'd1: begin
                            if (i_byte != 8'd0) begin
                                n_phase   = PH_IDLE;
                                o_push    = 1'b1;
                                o_cmd.kind = tsd_pkg::KIND_ERROR;
                                o_cmd.err  = tsd_pkg::ERR_CMAP;
                            end
                        end
                        5'd2: begin
                            if (i_byte == tsd_pkg::TYPE_PLAIN) begin
                                n_run_mode = 1'b0;
                            end else if (i_byte == tsd_pkg::TYPE_RLE) begin
                                n_run_mode = 1'b1;
                            end else begin
                                n_phase    = PH_IDLE;
                                o_push     = 1'b1;
                                o_cmd.kind = tsd_pkg::KIND_ERROR;
                                o_cmd.err  = tsd_pkg::ERR_TYPE;
                            end
                        end
                        5'd12: n_w[7:0]  = i_byte;
                        5'd13: n_w[15:8] = i_byte;
                        5'd14: n_h[7:0]  = i_byte;
                        5'd15: n_h[15:8] = i_byte;
                        5'd16: begin
                            n_area = 32'(r_w) * 32'(r_h);
                            if (i_byte == tsd_pkg::DEPTH_24) begin
                                n_pb4 = 1'b0;
                            end else if (i_byte == tsd_pkg::DEPTH_32) begin
                                n_pb4 = 1'b1;
                            end else begin
                                n_phase    = PH_IDLE;
                                o_push     = 1'b1;
                                o_cmd.kind = tsd_pkg::KIND_ERROR;
                                o_cmd.err  = tsd_pkg::ERR_DEPTH;
                            end
                        end
                        5'd17: begin
                            n_flip_c = (i_byte & tsd_pkg::DESC_RIGHT) != 8'd0;
                            n_flip_r = (i_byte & tsd_pkg::DESC_TOP) == 8'd0;
                            o_push   = 1'b1;
                            if ((i_byte & tsd_pkg::DESC_ALPHA) != 8'd0 &&
                                (i_byte[3:0] != tsd_pkg::ALPHA_8)) begin
                                n_phase    = PH_IDLE;
                                o_cmd.kind = tsd_pkg::KIND_ERROR;
                                o_cmd.err  = tsd_pkg::ERR_DESC;
                            end else begin
                                n_bidx     = 2'd0;
                                n_pkt_left = 8'd0;
                                n_is_run   = 1'b0;
                                n_left     = r_area;
                                if (empty) begin
                                    n_phase = PH_IDLE;
                                end else if (r_skip != 8'd0) begin
                                    n_phase = PH_SKIP;
                                end else begin
                                    n_phase = data_ph;
                                end
                                o_cmd.kind      = tsd_pkg::KIND_HEADER;
                                o_cmd.count     = r_pb4 ? 8'd4 : 8'd3;
                                o_cmd.col       = r_w;
                                o_cmd.row       = r_h;
                                o_cmd.last      = empty;
                                o_cmd.flip_rows = n_flip_r;
                                o_cmd.flip_cols = n_flip_c;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_SKIP: begin
                    n_skip = (r_skip != 8'd0) ? r_skip - 8'd1 : r_skip;
                    if (n_skip == 8'd0) begin
                        n_phase = data_ph;
                    end
                end
                PH_PACKET: begin
                    n_is_run   = (i_byte & tsd_pkg::RUN_FLAG) != 8'd0;
                    n_pkt_left = (i_byte & tsd_pkg::RUN_LEN) + 8'd1;
                    n_bidx     = 2'd0;
                    n_phase    = PH_PIXEL;
                end
                PH_PIXEL: begin
                    if (!pix_done) begin
                        unique case (r_bidx)
                            2'd0:    n_asm[7:0]   = i_byte;
                            2'd1:    n_asm[15:8]  = i_byte;
                            default: n_asm[23:16] = i_byte;
                        endcase
                        n_bidx = r_bidx + 2'd1;
                    end else begin
                        o_push      = 1'b1;
                        o_cmd.kind  = tsd_pkg::KIND_PIXEL;
                        o_cmd.blue  = r_asm[7:0];
                        o_cmd.green = r_asm[15:8];
                        o_cmd.red   = r_pb4 ? r_asm[23:16] : i_byte;
                        o_cmd.alpha = r_pb4 ? i_byte : 8'd0;
                        o_cmd.count = cnt;
                        o_cmd.last  = img_done;
                        n_left      = r_left - 32'(cnt);
                        n_bidx      = 2'd0;
                        if (r_run_mode) begin
                            if (r_is_run) begin
                                n_pkt_left = 8'd0;
                            end else if (r_pkt_left != 8'd0) begin
                                n_pkt_left = r_pkt_left - 8'd1;
                            end
                        end
                        if (img_done) begin
                            n_phase = PH_IDLE;
                        end else if (r_run_mode && n_pkt_left == 8'd0) begin
                            n_phase = PH_PACKET;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hidx  <= 5'd0;
        end else begin
            r_phase <= n_phase;
            r_hidx  <= n_hidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_skip     <= n_skip;
        r_run_mode <= n_run_mode;
        r_w        <= n_w;
        r_h        <= n_h;
        r_pb4      <= n_pb4;
        r_flip_r   <= n_flip_r;
        r_flip_c   <= n_flip_c;
        r_is_run   <= n_is_run;
        r_pkt_left <= n_pkt_left;
        r_bidx     <= n_bidx;
        r_asm      <= n_asm;
        r_area     <= n_area;
        r_left     <= n_left;
    end

endmodule

/* hw/rtl/tsd_fifo.sv */
module tsd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tsd_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output tsd_pkg::t_cmd o_cmd
);

    tsd_pkg::t_cmd r_mem [tsd_pkg::QDEPTH];

    logic [tsd_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [tsd_pkg::QCNT_W-1:0] r_cnt;
    logic                       do_push, do_pop;

    assign o_full  = (r_cnt == tsd_pkg::QCNT_W'(tsd_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

/* hw/rtl/tsd_back.sv */
module tsd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tsd_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output tsd_pkg::t_cmd o_res
);

    logic [15:0] r_w, r_h;
    logic        r_fr, r_fc;
    logic [16:0] r_col;
    logic [15:0] r_row;
    logic        r_out_valid;
    tsd_pkg::t_cmd r_out;

    logic        is_pix;
    logic        col_ok;
    logic        slot_free;
    logic [15:0] dcol, drow;
    tsd_pkg::t_cmd out_cmd;

    assign is_pix    = (i_cmd.kind == tsd_pkg::KIND_PIXEL);
    assign col_ok    = (r_col < {1'b0, r_w});
    assign slot_free = !r_out_valid || i_ready;
    assign o_pop     = i_valid && slot_free && (!is_pix || col_ok);
    assign dcol      = r_fc ? r_w - 16'd1 - r_col[15:0] : r_col[15:0];
    assign drow      = r_fr ? r_h - 16'd1 - r_row : r_row;
    assign o_valid   = r_out_valid;
    assign o_res     = r_out;

    always_comb begin
        out_cmd = i_cmd;
        if (is_pix) begin
            out_cmd.col = dcol;
            out_cmd.row = drow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= out_cmd;
            if (is_pix) begin
                r_col <= r_col + 17'(i_cmd.count);
            end else if (i_cmd.kind == tsd_pkg::KIND_HEADER) begin
                r_w   <= i_cmd.col;
                r_h   <= i_cmd.row;
                r_fr  <= i_cmd.flip_rows;
                r_fc  <= i_cmd.flip_cols;
                r_col <= 17'd0;
                r_row <= 16'd0;
            end
        end else if (!col_ok) begin
            r_col <= r_col - {1'b0, r_w};
            r_row <= r_row + 16'd1;
        end
    end

endmodule
